/* src/q2e_pkg.sv */
package q2e_pkg;

   // fixed-point formats
   localparam int QUAT_FRAC_BITS  = 14;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STAGES   = 16;
   localparam int WORK_FRAC       = 30;

   // datapath widths
   localparam int SUM_W   = 35;
   localparam int S30_W   = 32;
   localparam int SQ_W    = 2 * WORK_FRAC + 1;
   localparam int RT_W    = 2 * WORK_FRAC + 2;
   localparam int ROOT_W  = WORK_FRAC + 1;
   localparam int SQRT_STEPS = WORK_FRAC + 1;
   localparam int CORD_W  = 40;
   localparam int ANG_W   = 34;
   localparam int S_SHIFT = WORK_FRAC - 2 * QUAT_FRAC_BITS;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   // operands handed from the product stages to the angle units
   typedef struct packed {
      logic signed [SUM_W-1:0] rnum;
      logic signed [SUM_W-1:0] rden;
      logic signed [SUM_W-1:0] ynum;
      logic signed [SUM_W-1:0] yden;
      logic signed [S30_W-1:0] s30;
      logic                    sat;
   } q2e_args_type;

   // atan(2^-i) in Q30 radians
   function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF; 16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
         18: v = 32'h00000FFF; 19: v = 32'h000007FF;  20: v = 32'h000003FF;
         21: v = 32'h000001FF; 22: v = 32'h000000FF;  23: v = 32'h0000007F;
         24: v = 32'h0000003F; 25: v = 32'h0000001F;  26: v = 32'h0000000F;
         27: v = 32'h00000008; 28: v = 32'h00000004;  29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return $signed({2'b00, v});
   endfunction

   // clamp to +-lim and round half up to the output format
   function automatic logic [15:0] to_angle(input logic signed [ANG_W-1:0] z,
                                            input logic signed [ANG_W-1:0] lim);
      logic signed [ANG_W-1:0] zc;
      logic signed [ANG_W:0]   t;
      zc = z;
      if (z > lim) zc = lim;
      if (z < -lim) zc = -lim;
      t = (ANG_W+1)'(zc) + ((ANG_W+1)'(1) <<< (WORK_FRAC - 1 - ANGLE_FRAC_BITS));
      t = t >>> (WORK_FRAC - ANGLE_FRAC_BITS);
      return t[15:0];
   endfunction

endpackage

/* src/q2e_products.sv */
module q2e_products (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [15:0]   quat_w,
   input  logic signed [15:0]   quat_x,
   input  logic signed [15:0]   quat_y,
   input  logic signed [15:0]   quat_z,
   output logic                 out_valid,
   output q2e_pkg::q2e_args_type out_args
);

   localparam logic signed [q2e_pkg::SUM_W-1:0] ONE =
      q2e_pkg::SUM_W'(1) <<< (2 * q2e_pkg::QUAT_FRAC_BITS);

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   logic               v1_ff, v2_ff;
   q2e_pkg::q2e_args_type args_ff, args_in;

   logic signed [q2e_pkg::SUM_W-1:0] s_val, s_clip;

   // stage one: all products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= quat_w * quat_x;
         yz_ff <= quat_y * quat_z;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
         zz_ff <= quat_z * quat_z;
         wy_ff <= quat_w * quat_y;
         zx_ff <= quat_z * quat_x;
      end
   end

   // stage two: sums and asin argument clamp
   always_comb begin
      args_in.rnum = (q2e_pkg::SUM_W'(wx_ff) + q2e_pkg::SUM_W'(yz_ff)) <<< 1;
      args_in.rden = ONE - ((q2e_pkg::SUM_W'(xx_ff) + q2e_pkg::SUM_W'(yy_ff)) <<< 1);
      args_in.ynum = (q2e_pkg::SUM_W'(wz_ff) + q2e_pkg::SUM_W'(xy_ff)) <<< 1;
      args_in.yden = ONE - ((q2e_pkg::SUM_W'(yy_ff) + q2e_pkg::SUM_W'(zz_ff)) <<< 1);
      s_val = (q2e_pkg::SUM_W'(wy_ff) - q2e_pkg::SUM_W'(zx_ff)) <<< 1;
      s_clip = s_val;
      args_in.sat = 1'b0;
      if (s_val > ONE) begin
         s_clip = ONE;
         args_in.sat = 1'b1;
      end else if (s_val < -ONE) begin
         s_clip = -ONE;
         args_in.sat = 1'b1;
      end
      args_in.s30 = q2e_pkg::S30_W'(s_clip <<< q2e_pkg::S_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         args_ff <= args_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_args  = args_ff;

endmodule

/* src/q2e_sqrt.sv */
module q2e_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  q2e_pkg::q2e_args_type       in_args,
   output logic                        out_valid,
   output q2e_pkg::q2e_args_type       out_args,
   output logic [q2e_pkg::ROOT_W-1:0]  root
);

   localparam int STEPS = q2e_pkg::SQRT_STEPS;
   localparam int RW    = q2e_pkg::RT_W;

   logic [q2e_pkg::SQ_W-1:0] sq_ff;
   logic                     sqv_ff;
   q2e_pkg::q2e_args_type    sqa_ff;
   logic [2*q2e_pkg::S30_W-1:0] sq_full;

   logic [RW-1:0]          n_ff [STEPS+1];
   logic [RW-1:0]          r_ff [STEPS+1];
   logic                   v_ff [STEPS+1];
   q2e_pkg::q2e_args_type  a_ff [STEPS+1];

   // square of the asin argument
   assign sq_full = (2*q2e_pkg::S30_W)'(in_args.s30 * in_args.s30);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= sq_full[q2e_pkg::SQ_W-1:0];
         sqa_ff <= in_args;
      end
   end

   // first step input: 1 - s^2 in Q60
   always_comb begin
      n_ff[0] = (RW'(1) << (2 * q2e_pkg::WORK_FRAC)) - RW'(sq_ff);
      r_ff[0] = '0;
      v_ff[0] = sqv_ff;
      a_ff[0] = sqa_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
      end else if (en) begin
         sqv_ff <= in_valid;
      end
   end

   // one root bit per stage
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - j));
      logic [RW-1:0] trial;
      logic [RW-1:0] n_in, r_in;

      assign trial = r_ff[j] + BIT;

      always_comb begin
         if (n_ff[j] >= trial) begin
            n_in = n_ff[j] - trial;
            r_in = (r_ff[j] >> 1) + BIT;
         end else begin
            n_in = n_ff[j];
            r_in = r_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[j+1] <= n_in;
            r_ff[j+1] <= r_in;
            a_ff[j+1] <= a_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_args  = a_ff[STEPS];
   assign root      = r_ff[STEPS][q2e_pkg::ROOT_W-1:0];

endmodule

/* src/q2e_cordic.sv */
module q2e_cordic #(
   parameter int STAGES = q2e_pkg::CORDIC_STAGES
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [q2e_pkg::CORD_W-1:0]  y_in,
   input  logic signed [q2e_pkg::CORD_W-1:0]  x_in,
   output logic signed [q2e_pkg::ANG_W-1:0]   z_out
);

   localparam int CW = q2e_pkg::CORD_W;
   localparam int AW = q2e_pkg::ANG_W;

   logic signed [CW-1:0] x_ff [STAGES+1];
   logic signed [CW-1:0] y_ff [STAGES+1];
   logic signed [AW-1:0] z_ff [STAGES+1];
   logic                 sp_ff [STAGES+1];
   logic signed [AW-1:0] sv_ff [STAGES+1];

   logic signed [CW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] z0_in, sv0_in;
   logic                 sp0_in;

   // axis cases and left half-plane fold
   always_comb begin
      x0_in  = x_in;
      y0_in  = y_in;
      z0_in  = '0;
      sp0_in = 1'b0;
      sv0_in = '0;
      if (y_in == '0) begin
         sp0_in = 1'b1;
         sv0_in = (x_in < 0) ? q2e_pkg::PI_Q30 : '0;
      end else if (x_in == '0) begin
         sp0_in = 1'b1;
         sv0_in = (y_in > 0) ? q2e_pkg::HALF_PI_Q30 : -q2e_pkg::HALF_PI_Q30;
      end else if (x_in < 0) begin
         z0_in = (y_in > 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
         x0_in = -x_in;
         y0_in = -y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= x0_in;
         y_ff[0]  <= y0_in;
         z_ff[0]  <= z0_in;
         sp_ff[0] <= sp0_in;
         sv_ff[0] <= sv0_in;
      end
   end

   // vectoring micro-rotations
   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [AW-1:0] ATAN = q2e_pkg::atan_val(i);
      logic signed [CW-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end
            sp_ff[i+1] <= sp_ff[i];
            sv_ff[i+1] <= sv_ff[i];
         end
      end
   end

   assign z_out = sp_ff[STAGES] ? sv_ff[STAGES] : z_ff[STAGES];

endmodule

/* src/quaternion_to_euler.sv */
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: quat_w, quat_x, quat_y, quat_z
// rsp      out        rsp_tvalid/tready    tdata: roll, pitch, yaw; tuser: saturated
//
// one item per cycle while the output is not stalled; the path runs through
// the 31-step square-root pipeline and then the CORDIC rotation stages
// the whole pipeline advances when the output register is empty or taken
// reset clears the valid bits only; a stall holds every stage in place
module quaternion_to_euler #(
   parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
   output logic [0:0]  rsp_tuser    // pitch_saturated
);

   localparam int CW = q2e_pkg::CORD_W;
   localparam int AW = q2e_pkg::ANG_W;

   logic                  en;
   logic                  p_valid, s_valid;
   q2e_pkg::q2e_args_type p_args, s_args;
   logic [q2e_pkg::ROOT_W-1:0] root;
   logic signed [AW-1:0]  roll_z, pitch_z, yaw_z;

   logic                  cv_ff  [CORDIC_STAGES+2];
   logic                  sat_ff [CORDIC_STAGES+2];

   logic                  rsp_valid_ff;
   logic [15:0]           roll_ff, yaw_ff;
   logic [14:0]           pitch_ff;
   logic                  sat_out_ff;
   logic [15:0]           pitch_full;

   // global advance
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   q2e_products u_products (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .quat_w    ($signed(req_tdata[15:0])),
      .quat_x    ($signed(req_tdata[31:16])),
      .quat_y    ($signed(req_tdata[47:32])),
      .quat_z    ($signed(req_tdata[63:48])),
      .out_valid (p_valid),
      .out_args  (p_args)
   );

   q2e_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_args   (p_args),
      .out_valid (s_valid),
      .out_args  (s_args),
      .root      (root)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock),
      .en    (en),
      .y_in  (CW'(s_args.rnum)),
      .x_in  (CW'(s_args.rden)),
      .z_out (roll_z)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock),
      .en    (en),
      .y_in  (CW'(s_args.s30)),
      .x_in  ($signed(CW'(root))),
      .z_out (pitch_z)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock),
      .en    (en),
      .y_in  (CW'(s_args.ynum)),
      .x_in  (CW'(s_args.yden)),
      .z_out (yaw_z)
   );

   // valid and flag alongside the rotation stages
   assign cv_ff[0]  = s_valid;
   assign sat_ff[0] = s_args.sat;

   for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (en) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   // output register with final clamp and rounding
   assign pitch_full = q2e_pkg::to_angle(pitch_z, q2e_pkg::HALF_PI_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cv_ff[CORDIC_STAGES+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff    <= q2e_pkg::to_angle(roll_z, q2e_pkg::PI_Q30);
         pitch_ff   <= pitch_full[14:0];
         yaw_ff     <= q2e_pkg::to_angle(yaw_z, q2e_pkg::PI_Q30);
         sat_out_ff <= sat_ff[CORDIC_STAGES+1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = sat_out_ff;

endmodule

/* tb/quaternion_to_euler_tb.sv */
module quaternion_to_euler_tb;

   localparam int LATENCY   = q2e_pkg::CORDIC_STAGES + 36;
   localparam int WATCHDOG  = 4000;
   localparam logic signed [63:0] PI_FIX      = 64'sd3373259426;
   localparam logic signed [63:0] HALF_PI_FIX = 64'sd1686629713;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               sat;
   } angles_type;

   // atan(2^-i) in Q30
   function automatic longint atan_step(input int i);
      longint t[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
      return t[i];
   endfunction

   // vectoring cordic, Q30 radians
   function automatic longint cordic_atan2(input longint y, input longint x);
      longint acc, xs, ys;
      acc = 0;
      if (y == 0) return (x < 0) ? PI_FIX : 0;
      if (x == 0) return (y > 0) ? HALF_PI_FIX : -HALF_PI_FIX;
      if (x < 0) begin
         acc = (y > 0) ? PI_FIX : -PI_FIX;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; acc = acc + atan_step(i);
         end else begin
            x = x - ys; y = y + xs; acc = acc - atan_step(i);
         end
      end
      return acc;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b); r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // clamp then round half up to Q13
   function automatic longint round_angle(input longint a, input longint lim);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      a = a + (64'sd1 <<< (29 - q2e_pkg::ANGLE_FRAC_BITS));
      return a >>> (30 - q2e_pkg::ANGLE_FRAC_BITS);
   endfunction

   function automatic angles_type euler_of(input logic [63:0] q);
      longint w, x, y, z, one, rnum, rden, ynum, yden, s, s30, c;
      angles_type a;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      one = 64'sd1 <<< (2 * q2e_pkg::QUAT_FRAC_BITS);
      rnum = 2 * (w * x + y * z);
      rden = one - 2 * (x * x + y * y);
      ynum = 2 * (w * z + x * y);
      yden = one - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      a.sat = 1'b0;
      if (s > one) begin
         s = one; a.sat = 1'b1;
      end else if (s < -one) begin
         s = -one; a.sat = 1'b1;
      end
      s30 = s <<< (30 - 2 * q2e_pkg::QUAT_FRAC_BITS);
      c = int_sqrt((64'd1 << 60) - longint'(s30 * s30));
      a.roll  = 16'(round_angle(cordic_atan2(rnum, rden), PI_FIX));
      a.pitch = 15'(round_angle(cordic_atan2(s30, c), HALF_PI_FIX));
      a.yaw   = 16'(round_angle(cordic_atan2(ynum, yden), PI_FIX));
      return a;
   endfunction

   class angle_scoreboard;
      angles_type pending[$];
      int      mismatches = 0;
      int      checked = 0;
      int      saturated = 0;

      function void note_quat(input logic [63:0] q);
         pending.push_back(euler_of(q));
      endfunction

      function void check_angles(input logic [47:0] d, input logic u);
         angles_type want, got;
         got.roll = d[15:0];
         got.pitch = d[30:16];
         got.yaw = d[46:31];
         got.sat = u;
         checked++;
         if (got.sat) saturated++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: tdata %h tuser %b", d, u);
            return;
         end
         want = pending.pop_front();
         if (got.roll !== want.roll || got.pitch !== want.pitch ||
             got.yaw !== want.yaw || got.sat !== want.sat || d[47] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d sat %b/%b (exp/act)",
                        want.roll, got.roll, want.pitch, got.pitch,
                        want.yaw, got.yaw, want.sat, got.sat);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // roll, pitch, yaw, zero pad
   logic [0:0]  rsp_tuser;        // pitch_saturated

   angle_scoreboard board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int sent = 0;

   quaternion_to_euler dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: check and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_angles(rsp_tdata, rsp_tuser[0]);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("watchdog expired");
         $display("status: fail");
         $finish;
      end
   end

   // valid stays high between back-to-back items and drops only on idle cycles
   task automatic send_quat(input logic [15:0] w, x, y, z);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_quat(req_tdata);
      sent++;
   endtask

   function automatic logic [15:0] rand_comp(input int mode);
      case (mode)
         0: return 16'($urandom_range(32768) - 16384);
         1: return 16'($urandom());
         default: return 16'($urandom_range(400) - 200);
      endcase
   endfunction

   // random quaternion, mostly near unit norm
   task automatic send_random();
      real a, b, c, d, n;
      int m;
      m = $urandom_range(9);
      if (m < 7) begin
         a = real'($signed(16'($urandom()))); b = real'($signed(16'($urandom())));
         c = real'($signed(16'($urandom()))); d = real'($signed(16'($urandom())));
         n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
         send_quat(16'($rtoi(a * 16380.0 / n)), 16'($rtoi(b * 16380.0 / n)),
                   16'($rtoi(c * 16380.0 / n)), 16'($rtoi(d * 16380.0 / n)));
      end else begin
         m = $urandom_range(2);
         send_quat(rand_comp(m), rand_comp(m), rand_comp(m), rand_comp(m));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, axes, gimbal lock, saturation, zero, extremes
      send_quat(16'sd16384, 0, 0, 0);
      send_quat(0, 16'sd16384, 0, 0);
      send_quat(0, 0, 16'sd16384, 0);
      send_quat(0, 0, 0, 16'sd16384);
      send_quat(-16'sd16384, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(16'sd11585, 0, 16'sd11585, 0);
      send_quat(16'sd11585, 0, -16'sd11585, 0);
      send_quat(16'sd16384, 0, 16'sd16384, 0);
      send_quat(16'sd16384, 0, -16'sd16384, 0);
      send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
      send_quat(0, 16'sd11585, 0, 16'sd11585);
      send_quat(16'sd11585, 16'sd11585, 0, 0);
      send_quat(16'sd11585, 0, 0, 16'sd11585);
      send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

      // random phases with varying idle and stall mixes
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            3: begin idle_pct = 25; stall_pct = 25; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (130) send_random();
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("sent %0d quaternions, checked %0d angle sets, %0d with pitch clamped",
               sent, board.checked, board.saturated);
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/q2e_pkg.sv
src/q2e_products.sv
src/q2e_sqrt.sv
src/q2e_cordic.sv
src/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
